@@ rtl/core/bitmap_bit_allocator_assert.svh @@
// Assertion macros for the bitmap bit allocator.
// Used by bitmap_bit_allocator to check its own logic; needs clk and arst_n in scope.
`ifndef BITMAP_BIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_BIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication and next-cycle implication, disabled in reset.
`ifndef SYNTH
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBA_ASSERT_NOW(lbl, ante, cons, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/bba_pkg.sv @@
// Shared types, codes and helpers for the bitmap bit allocator.
// No dependencies; imported by every module under rtl/core.
package bba_pkg;

	localparam int WORD_W     = 32;
	localparam int BIT_POS_W  = 5;
	localparam int WORD_IDX_W = 5;
	localparam int IDX_WORDS  = 32;
	localparam int CNT_W      = 6;
	localparam int INDEX_W    = 10;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_FREE  = 3'd1,
		CMD_SET   = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_TEST  = 3'd4
	} cmd_t;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_FREE_CLEAR = 2'd2;
	localparam logic [1:0] ST_RANGE      = 2'd3;

	// write-back notice to the per-word flags
	typedef struct packed {
		logic                  we;
		logic [WORD_IDX_W-1:0] word;
		logic                  full;
	} flag_upd_t;

	// first word with room among the active words
	typedef struct packed {
		logic                  found;
		logic [WORD_IDX_W-1:0] word;
	} search_t;

	// position of the lowest set bit; zero when none is set
	function automatic logic [BIT_POS_W-1:0] ffs32(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0]    iso;
		logic [BIT_POS_W-1:0] pos;
		iso = v & (~v + WORD_W'(1));
		pos = '0;
		for (int k = 0; k < BIT_POS_W; k++) begin
			for (int i = 0; i < WORD_W; i++) begin
				if (((i >> k) & 1) != 0) begin
					pos[k] = pos[k] | iso[i];
				end
			end
		end
		return pos;
	endfunction

endpackage

@@ rtl/core/bitmap_bit_allocator.sv @@
// Bitmap bit allocator: a map of 32-bit words, all clear after reset, that
// hands out and takes back single bits. Each item carries a command
// (allocate, free, set, clear, test) and a bit index; each gives exactly one
// result item with a status, the allocated index and the prior bit value.
// An item goes through S_IDLE and S_EXEC: the accept edge reads the map word from
// the map memory, and the commit edge in S_EXEC modifies and writes it back and
// loads the result register. The word for allocate comes from per-word full
// flags at accept time, so no scan over the memory is needed. A new item is
// taken as soon as the write-back is done, even if the last result is still
// waiting on out_stall; a result waits in its state only while the result
// register is occupied. No clearing pass after reset: per-word valid flags
// make unwritten words read as zero. words_in_use is only sampled when an
// item is accepted; write it while the block is idle.
module bitmap_bit_allocator import bba_pkg::*; #(
	parameter int MAP_WORDS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [INDEX_W-1:0] bit_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [INDEX_W-1:0] result_index,
	output logic               bit_value
);

`include "bitmap_bit_allocator_assert.svh"

	// a 10-bit index reaches no further than 32 words
	localparam int DEPTH = (MAP_WORDS < IDX_WORDS) ? MAP_WORDS : IDX_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      words_in_use_q;
	logic [CNT_W-1:0]      words_active;

	cmd_t                  cmd_s1;
	logic [WORD_IDX_W-1:0] word_s1;
	logic [BIT_POS_W-1:0]  pos_s1;
	logic                  miss_s1;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [INDEX_W-1:0]    result_index_q;
	logic                  bit_value_q;

	logic                  accept;
	logic                  commit;
	search_t               search;
	logic                  rd_valid;
	logic [WORD_W-1:0]     rd_data;
	logic [WORD_IDX_W-1:0] in_word;
	logic                  in_miss;
	flag_upd_t             upd;

	logic [WORD_W-1:0]     cur_word;
	logic [WORD_W-1:0]     bit_mask;
	logic [BIT_POS_W-1:0]  free_pos;
	logic                  cur_bit;
	logic                  wr_en;
	logic [WORD_W-1:0]     new_word;
	logic [1:0]            st_next;
	logic [INDEX_W-1:0]    ridx_next;
	logic                  bval_next;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= CNT_W'(IDX_WORDS);
		end else if (cfg_we) begin
			words_in_use_q <= cfg_wdata;
		end
	end

	assign words_active = (words_in_use_q > DEPTH_CNT) ? DEPTH_CNT : words_in_use_q;

	// accept side: pick the word to read
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (cmd_t'(command) == CMD_ALLOC) begin
			in_word = search.word;
			in_miss = !search.found;
		end else begin
			in_word = bit_index[INDEX_W-1 -: WORD_IDX_W];
			in_miss = (CNT_W'(bit_index[INDEX_W-1 -: WORD_IDX_W]) >= words_active);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(command);
			word_s1 <= in_word;
			pos_s1  <= bit_index[BIT_POS_W-1:0];
			miss_s1 <= in_miss;
		end
	end

	bba_flags #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_flags (
		.clk          (clk),
		.arst_n       (arst_n),
		.words_active (words_active),
		.upd          (upd),
		.rd_word      (word_s1),
		.rd_valid     (rd_valid),
		.search       (search)
	);

	bba_map_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (commit && wr_en),
		.waddr (word_s1[AW-1:0]),
		.wdata (new_word),
		.re    (accept),
		.raddr (in_word[AW-1:0]),
		.rdata (rd_data)
	);

	// modify: work on the word read at accept
	assign cur_word = rd_valid ? rd_data : '0;
	assign free_pos = ffs32(~cur_word);
	assign cur_bit  = cur_word[pos_s1];
	assign bit_mask = WORD_W'(1) << pos_s1;

	always_comb begin
		wr_en     = 1'b0;
		new_word  = cur_word;
		st_next   = ST_OK;
		ridx_next = '0;
		bval_next = 1'b0;
		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (miss_s1) begin
					st_next = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					new_word  = cur_word | (WORD_W'(1) << free_pos);
					ridx_next = {word_s1, free_pos};
				end
			end
			CMD_FREE: begin
				if (miss_s1) begin
					st_next = ST_RANGE;
				end else if (!cur_bit) begin
					st_next = ST_FREE_CLEAR;
				end else begin
					bval_next = 1'b1;
					wr_en     = 1'b1;
					new_word  = cur_word & ~bit_mask;
				end
			end
			CMD_SET: begin
				if (miss_s1) begin
					st_next = ST_RANGE;
				end else begin
					bval_next = cur_bit;
					wr_en     = 1'b1;
					new_word  = cur_word | bit_mask;
				end
			end
			CMD_CLEAR: begin
				if (miss_s1) begin
					st_next = ST_RANGE;
				end else begin
					bval_next = cur_bit;
					wr_en     = 1'b1;
					new_word  = cur_word & ~bit_mask;
				end
			end
			CMD_TEST: begin
				if (miss_s1) begin
					st_next = ST_RANGE;
				end else begin
					bval_next = cur_bit;
				end
			end
			default: begin
				// unused codes: drop, no write and an all-zero result
			end
		endcase
	end

	// commit once the result register is free or being emptied
	assign commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall);

	assign upd.we   = commit && wr_en;
	assign upd.word = word_s1;
	assign upd.full = &new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q       <= st_next;
			result_index_q <= ridx_next;
			bit_value_q    <= bval_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_index = result_index_q;
	assign bit_value    = bit_value_q;

	`BBA_ASSERT_NEXT(a_accept_exec, accept, state_q == S_EXEC, "accepted item did not enter execute")
	`BBA_ASSERT_NEXT(a_rd_hold, (state_q == S_EXEC) && !commit, $stable(rd_data), "map word lost while waiting")
	`BBA_ASSERT_NOW(a_full_zero, out_valid_q && (status_q == ST_FULL), result_index_q == '0, "full result carries an index")
	`BBA_ASSERT_NOW(a_fail_bval, out_valid_q && (status_q == ST_RANGE || status_q == ST_FREE_CLEAR), !bit_value_q, "failed item reports a bit value")

endmodule

@@ rtl/core/bba_map_ram.sv @@
// Map word memory: one write port, one read port with registered data.
// Depends on bba_pkg for the word width.
module bba_map_ram import bba_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/bba_flags.sv @@
// Per-word valid and full flags, and the search for the first word with room.
// Depends on bba_pkg for flag_upd_t, search_t and ffs32.
module bba_flags import bba_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CNT_W-1:0]      words_active,
	input  flag_upd_t             upd,
	input  logic [WORD_IDX_W-1:0] rd_word,
	output logic                  rd_valid,
	output search_t               search
);

	logic [DEPTH-1:0]  valid_q;
	logic [DEPTH-1:0]  full_q;
	logic [WORD_W-1:0] room;

	// a word never written reads as zero, so it has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			full_q  <= '0;
		end else if (upd.we) begin
			valid_q[upd.word[AW-1:0]] <= 1'b1;
			full_q[upd.word[AW-1:0]]  <= upd.full;
		end
	end

	for (genvar i = 0; i < IDX_WORDS; i++) begin : g_room
		if (i < DEPTH) begin : g_real
			assign room[i] = !full_q[i] && (CNT_W'(i) < words_active);
		end else begin : g_none
			assign room[i] = 1'b0;
		end
	end

	assign rd_valid     = valid_q[rd_word[AW-1:0]];
	assign search.found = |room;
	assign search.word  = ffs32(room);

endmodule

@@ test/bitmap_bit_allocator_checker.sv @@
// Result checker for the bitmap bit allocator: predicts every result from accepted items.
// Depends on bba_pkg; instantiated beside the block by bitmap_bit_allocator_test.
`timescale 1ns / 1ps

module bitmap_bit_allocator_checker import bba_pkg::*; #(
	parameter int MAP_WORDS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         command,
	input  logic [INDEX_W-1:0] bit_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic [INDEX_W-1:0] result_index,
	input  logic               bit_value,
	output int                 fail_count,
	output int                 pending,
	output int                 checked,
	output int                 grants,
	output int                 full_hits,
	output int                 free_clear_hits,
	output int                 range_hits
);

	typedef struct packed {
		logic [1:0]         status;
		logic [INDEX_W-1:0] slot;
		logic               was_set;
	} bit_outcome_t;

	logic [WORD_W-1:0] map_words [MAP_WORDS];
	logic [CNT_W-1:0]  words_reg;
	bit_outcome_t      outcome_q [$];
	bit_outcome_t      want;

	function automatic int live_words();
		int n;
		n = int'(words_reg);
		if (n > MAP_WORDS) n = MAP_WORDS;
		if (n > IDX_WORDS) n = IDX_WORDS;
		return n;
	endfunction

	// apply one command to the local map and return the outcome it should give
	function automatic bit_outcome_t apply_command(input logic [2:0] cmd,
			input logic [INDEX_W-1:0] idx);
		bit_outcome_t r;
		int           n;
		int           w;
		logic         done;
		r = '0;
		n = live_words();
		done = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				r.status = ST_FULL;
				for (int wi = 0; wi < n && !done; wi++) begin
					if (map_words[wi] != '1) begin
						for (int b = 0; b < WORD_W && !done; b++) begin
							if (!map_words[wi][b]) begin
								map_words[wi][b] = 1'b1;
								r.status = ST_OK;
								r.slot = INDEX_W'(wi * WORD_W + b);
								done = 1'b1;
							end
						end
					end
				end
			end
			CMD_FREE, CMD_SET, CMD_CLEAR, CMD_TEST: begin
				w = idx / WORD_W;
				if (w >= n) begin
					r.status = ST_RANGE;
				end else begin
					r.was_set = map_words[w][idx[BIT_POS_W-1:0]];
					if (cmd == CMD_FREE) begin
						if (!r.was_set) begin
							r.status = ST_FREE_CLEAR;
							r.was_set = 1'b0;
						end else begin
							map_words[w][idx[BIT_POS_W-1:0]] = 1'b0;
						end
					end else if (cmd == CMD_SET) begin
						map_words[w][idx[BIT_POS_W-1:0]] = 1'b1;
					end else if (cmd == CMD_CLEAR) begin
						map_words[w][idx[BIT_POS_W-1:0]] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) map_words[i] = '0;
			words_reg = CNT_W'(IDX_WORDS);
			outcome_q.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			grants = 0;
			full_hits = 0;
			free_clear_hits = 0;
			range_hits = 0;
		end else begin
			if (cfg_we) words_reg = cfg_wdata;
			// compare before pushing: a result never belongs to an item taken at the same edge
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result status %0d index %0d bit %0d",
						$time, status, result_index, bit_value);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					checked++;
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
						fail_count++;
					end
					if (result_index !== want.slot) begin
						$display("%0t: result_index expected %0d got %0d",
							$time, want.slot, result_index);
						fail_count++;
					end
					if (bit_value !== want.was_set) begin
						$display("%0t: bit_value expected %0d got %0d",
							$time, want.was_set, bit_value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_command(command, bit_index);
				if (command == CMD_ALLOC && want.status == ST_OK) grants++;
				if (want.status == ST_FULL) full_hits++;
				if (want.status == ST_FREE_CLEAR) free_clear_hits++;
				if (want.status == ST_RANGE) range_hits++;
				outcome_q.push_back(want);
			end
			pending = outcome_q.size();
		end
	end

endmodule

@@ test/bitmap_bit_allocator_test.sv @@
// Top of the bitmap bit allocator testbench: clock, reset, items, register writes, verdict.
// Depends on bba_pkg, bitmap_bit_allocator and bitmap_bit_allocator_checker.
`timescale 1ns / 1ps

module bitmap_bit_allocator_test;
	import bba_pkg::*;

	localparam int MAP_WORDS = 32;
	localparam int LIMIT     = 300000;
	localparam int PHASES    = 10;

	// command codes the block ignores
	localparam logic [2:0] CMD_SPARE_5 = 3'd5;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CNT_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         command;
	logic [INDEX_W-1:0] bit_index;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [INDEX_W-1:0] result_index;
	logic               bit_value;

	int fail_count, pending, checked, grants, full_hits, free_clear_hits, range_hits;

	// idle_on gates all idling; burst_window opens and shuts to leave calm stretches
	logic idle_on;
	logic burst_window;
	int   stall_left;
	int   fill_hint;
	int   settings_used;
	int   cycle_count;

	// register settings per phase: tiny maps fill up fast, 0 switches every word off,
	// 33 and 63 must clamp to the full map
	int phase_words [PHASES] = '{1, 2, 63, 33, 3, 0, 32, 8, 1, 32};
	int phase_items [PHASES] = '{200, 200, 200, 180, 200, 40, 200, 200, 200, 200};

	bitmap_bit_allocator #(.MAP_WORDS(MAP_WORDS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.bit_index    (bit_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_index (result_index),
		.bit_value    (bit_value)
	);

	bitmap_bit_allocator_checker #(.MAP_WORDS(MAP_WORDS)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.bit_index       (bit_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.result_index    (result_index),
		.bit_value       (bit_value),
		.fail_count      (fail_count),
		.pending         (pending),
		.checked         (checked),
		.grants          (grants),
		.full_hits       (full_hits),
		.free_clear_hits (free_clear_hits),
		.range_hits      (range_hits)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: far beyond the slowest correct run (about 2000 items, each with its
	// block time plus an input gap plus a receiver stall).
	initial begin
		for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Flip the idling window now and then, on the rising edge so the negedge
	// drivers all see one settled value.
	initial begin
		burst_window = 1'b1;
		forever begin
			repeat ($urandom_range(30, 120)) @(posedge clk);
			burst_window <= ($urandom_range(0, 2) != 0);
		end
	end

	// Receiver side: stall in random bursts while idling is allowed.
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (idle_on && burst_window && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Offer one item and hold it until the block takes it. A gap with valid low
	// may come first; the payload never moves while stalled.
	task automatic send_item(input logic [2:0] cmd, input logic [INDEX_W-1:0] idx);
		@(negedge clk);
		if (idle_on && burst_window && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		bit_index = idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid and hold off until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Write the word count only once the block is idle; give the write-back slack first.
	task automatic write_words(input int words);
		drain();
		repeat (2) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = CNT_W'(words);
		@(negedge clk);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	// Random phase. Allocate and free dominate so the map fills and empties;
	// frees aim low, where allocate has packed the set bits. A few items go
	// anywhere in the index space to hit the range check, and a few use the
	// spare codes.
	task automatic run_phase(input int words, input int items);
		int                 span;
		int                 r;
		logic [2:0]         cmd;
		logic [INDEX_W-1:0] idx;
		write_words(words);
		span = (words > MAP_WORDS ? MAP_WORDS : words) * WORD_W;
		if (fill_hint > span) fill_hint = span;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			idx = (span > 0) ? INDEX_W'($urandom_range(0, span - 1))
				: INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
			if (r < 40) begin
				cmd = CMD_ALLOC;
				idx = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
				if (fill_hint < span) fill_hint++;
			end else if (r < 65) begin
				cmd = CMD_FREE;
				if (fill_hint > 0 && $urandom_range(0, 3) != 0) begin
					idx = INDEX_W'($urandom_range(0, fill_hint - 1));
					fill_hint--;
				end
			end else if (r < 73) begin
				cmd = CMD_SET;
			end else if (r < 81) begin
				cmd = CMD_CLEAR;
			end else if (r < 93) begin
				cmd = CMD_TEST;
			end else if (r < 97) begin
				cmd = 3'($urandom_range(CMD_FREE, CMD_TEST));
				idx = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
			end else begin
				cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
				idx = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
			end
			send_item(cmd, idx);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		command = CMD_ALLOC;
		bit_index = '0;
		idle_on = 1'b1;
		fill_hint = 0;
		settings_used = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset setting of 32 words: lowest-first allocate,
		// both index extremes, free of a set bit and of a clear bit, the spare codes.
		send_item(CMD_ALLOC, '0);
		send_item(CMD_ALLOC, '1);
		send_item(CMD_TEST, '0);
		send_item(CMD_TEST, '1);
		send_item(CMD_SET, '1);
		send_item(CMD_TEST, '1);
		send_item(CMD_CLEAR, '1);
		send_item(CMD_FREE, INDEX_W'(1));
		send_item(CMD_FREE, INDEX_W'(1));
		send_item(CMD_ALLOC, '0);
		send_item(CMD_SET, INDEX_W'(2));
		send_item(CMD_ALLOC, '0);
		send_item(CMD_SPARE_5, '0);
		send_item(3'(CMD_SPARE_5 + 1), '1);
		send_item(CMD_SPARE_7, INDEX_W'(512));
		send_item(CMD_FREE, '1);
		send_item(CMD_TEST, INDEX_W'(512));

		// No words in use: allocate reports full and every index is out of range.
		write_words(0);
		send_item(CMD_ALLOC, '0);
		send_item(CMD_TEST, '0);
		send_item(CMD_SET, '1);

		// One word: the boundary between word 0 and word 1.
		write_words(1);
		send_item(CMD_TEST, INDEX_W'(WORD_W - 1));
		send_item(CMD_TEST, INDEX_W'(WORD_W));
		send_item(CMD_FREE, '1);

		// Random phases; the last one runs with no idling on either side.
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) idle_on = 1'b0;
			run_phase(phase_words[p], phase_items[p]);
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Checked %0d results across %0d register settings.", checked, settings_used);
		$display("Allocations granted %0d, map full %0d, frees of clear bits %0d, out of range %0d.",
			grants, full_hits, free_clear_hits, range_hits);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
